>>> src/rws_pkg.sv
// Shared widths and codes for the roulette wheel selector.
// No dependencies; imported by roulette_wheel_selector, rws_mul and the testbench.
package rws_pkg;

  localparam int TOT_W     = 40;
  localparam int SQ_W      = 32;
  localparam int RAW_W     = 16;
  localparam int FRAC_W    = 24;
  localparam int MUL_A_W   = 24;
  localparam int MUL_B_W   = 20;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int ACC_W     = 64;
  localparam int STATUS_W  = 2;
  localparam int IDXO_W    = 8;

  localparam logic [TOT_W-1:0] TOTAL_MAX = '1;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_DRAW = 1'b1;

  localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_TOO_FEW = 2'd2;

endpackage

>>> src/roulette_wheel_selector.sv
// Roulette wheel selector top level: sequencer, generation state, result register.
// Depends on rws_pkg, rws_mul (shared multiplier) and rws_ram (cumulative table).
//
//   channel | valid      | stall       | payload
//   --------+------------+-------------+-------------------------------------------------
//   in      | in_valid_i | in_stall_o  | func_i first_of_generation_i raw_fitness_i
//           |            |             | draw_fraction_i
//   out     | out_valid_o| out_stall_i | status_o selected_index_o best_index_o
//           |            |             | total_fitness_o
//
// Load item: square in shared multiplier, update, result.
// Draw item: two multiplier passes and an accumulate, then one table read and compare
// per search step.
// Full table or too few entries: straight to the result.
// Reset clears the entry count, total and best tracking; the table needs no clearing.
// The input stalls while an item is in progress; the next item is taken while a
// finished result still waits on the output register.
module roulette_wheel_selector
  import rws_pkg::*;
#(
  parameter int MAX_POPULATION = 256,
  parameter int FITNESS_BITS   = 16,
  parameter int DRAW_BITS      = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                func_i,
  input  logic                first_of_generation_i,
  input  logic [RAW_W-1:0]    raw_fitness_i,
  input  logic [FRAC_W-1:0]   draw_fraction_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [IDXO_W-1:0]   selected_index_o,
  output logic [IDXO_W-1:0]   best_index_o,
  output logic [TOT_W-1:0]    total_fitness_o
);

  localparam int IDX_W    = $clog2(MAX_POPULATION);
  localparam int CNT_W    = $clog2(MAX_POPULATION + 1);
  localparam int FIT_EFF  = (FITNESS_BITS < RAW_W) ? FITNESS_BITS : RAW_W;
  localparam int DRAW_EFF = (DRAW_BITS < FRAC_W) ? DRAW_BITS : FRAC_W;

  localparam logic [RAW_W-1:0]  FIT_MASK  = RAW_W'((64'd1 << FIT_EFF) - 64'd1);
  localparam logic [FRAC_W-1:0] DRAW_MASK = FRAC_W'((64'd1 << DRAW_EFF) - 64'd1);
  localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_POPULATION);
  localparam logic [CNT_W-1:0]  CNT_TWO   = CNT_W'(2);

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] ST_IDLE     = 4'd0;
  localparam logic [ST_W-1:0] ST_SQ       = 4'd1;
  localparam logic [ST_W-1:0] ST_LOAD_UPD = 4'd2;
  localparam logic [ST_W-1:0] ST_MUL_LO   = 4'd3;
  localparam logic [ST_W-1:0] ST_MUL_HI   = 4'd4;
  localparam logic [ST_W-1:0] ST_ACC      = 4'd5;
  localparam logic [ST_W-1:0] ST_SRCH_RD  = 4'd6;
  localparam logic [ST_W-1:0] ST_SRCH_CMP = 4'd7;
  localparam logic [ST_W-1:0] ST_DONE     = 4'd8;

  logic [ST_W-1:0]     state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [TOT_W-1:0]    total_q, total_d;
  logic [IDX_W-1:0]    best_slot_q, best_slot_d;
  logic [SQ_W-1:0]     best_val_q, best_val_d;
  logic                out_valid_q, out_valid_d;

  logic [RAW_W-1:0]    raw_q, raw_d;
  logic [FRAC_W-1:0]   frac_q, frac_d;
  logic [ACC_W-1:0]    acc_q, acc_d;
  logic [IDX_W-1:0]    lo_q, lo_d;
  logic [IDX_W-1:0]    hi_q, hi_d;
  logic [IDX_W-1:0]    mid_q, mid_d;
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [IDXO_W-1:0]   res_sel_q, res_sel_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic [IDXO_W-1:0]   out_sel_q, out_sel_d;
  logic [IDXO_W-1:0]   out_best_q, out_best_d;
  logic [TOT_W-1:0]    out_total_q, out_total_d;

  logic                in_accept;
  logic [CNT_W-1:0]    cnt_eff;
  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic [MUL_P_W-1:0]  mul_p;
  logic [SQ_W-1:0]     sq;
  logic [TOT_W:0]      sum;
  logic [IDX_W-1:0]    mid_w;
  logic [IDX_W-1:0]    slot;
  logic [TOT_W-1:0]    target;
  logic                ram_we;
  logic [TOT_W-1:0]    ram_rdata;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign cnt_eff    = (func_i == FUNC_LOAD && first_of_generation_i) ? '0 : count_q;
  assign sq         = mul_p[SQ_W-1:0];
  assign sum        = {1'b0, total_q} + (TOT_W + 1)'(sq);
  assign mid_w      = IDX_W'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
  assign slot       = count_q[IDX_W-1:0];
  assign target     = TOT_W'(acc_q >> DRAW_BITS);

  rws_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  rws_ram #(
    .WIDTH (TOT_W),
    .DEPTH (MAX_POPULATION)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot),
    .wdata_i (total_d),
    .raddr_i (mid_w),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    total_d      = total_q;
    best_slot_d  = best_slot_q;
    best_val_d   = best_val_q;
    raw_d        = raw_q;
    frac_d       = frac_q;
    acc_d        = acc_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    mid_d        = mid_q;
    res_status_d = res_status_q;
    res_sel_d    = res_sel_q;
    out_status_d = out_status_q;
    out_sel_d    = out_sel_q;
    out_best_d   = out_best_q;
    out_total_d  = out_total_q;
    out_valid_d  = out_valid_q && out_stall_i;
    mul_a        = '0;
    mul_b        = '0;
    ram_we       = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          raw_d  = raw_fitness_i & FIT_MASK;
          frac_d = draw_fraction_i & DRAW_MASK;
          if (func_i == FUNC_LOAD) begin
            if (first_of_generation_i) begin
              count_d    = '0;
              total_d    = '0;
              best_val_d = '0;
            end
            if (cnt_eff == CNT_MAX) begin
              res_status_d = STAT_FULL;
              res_sel_d    = '0;
              state_d      = ST_DONE;
            end else begin
              state_d = ST_SQ;
            end
          end else begin
            if (count_q < CNT_TWO) begin
              res_status_d = STAT_TOO_FEW;
              res_sel_d    = '0;
              state_d      = ST_DONE;
            end else begin
              lo_d    = '0;
              hi_d    = IDX_W'(count_q - CNT_W'(1));
              state_d = ST_MUL_LO;
            end
          end
        end
      end
      ST_SQ: begin
        mul_a   = MUL_A_W'(raw_q);
        mul_b   = MUL_B_W'(raw_q);
        state_d = ST_LOAD_UPD;
      end
      ST_LOAD_UPD: begin
        total_d = sum[TOT_W] ? TOTAL_MAX : sum[TOT_W-1:0];
        ram_we  = 1'b1;
        if (sq > best_val_q) begin
          best_val_d  = sq;
          best_slot_d = slot;
        end
        count_d      = count_q + CNT_W'(1);
        res_status_d = STAT_OK;
        res_sel_d    = IDXO_W'(slot);
        state_d      = ST_DONE;
      end
      ST_MUL_LO: begin
        mul_a   = frac_q;
        mul_b   = total_q[MUL_B_W-1:0];
        state_d = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        mul_a   = frac_q;
        mul_b   = total_q[TOT_W-1:MUL_B_W];
        acc_d   = ACC_W'(mul_p);
        state_d = ST_ACC;
      end
      ST_ACC: begin
        acc_d   = acc_q + (ACC_W'(mul_p) << MUL_B_W);
        state_d = ST_SRCH_RD;
      end
      ST_SRCH_RD: begin
        if (lo_q < hi_q) begin
          mid_d   = mid_w;
          state_d = ST_SRCH_CMP;
        end else begin
          res_status_d = STAT_OK;
          res_sel_d    = IDXO_W'(hi_q);
          state_d      = ST_DONE;
        end
      end
      ST_SRCH_CMP: begin
        if (ram_rdata > target) begin
          hi_d = mid_q;
        end else begin
          lo_d = mid_q + IDX_W'(1);
        end
        state_d = ST_SRCH_RD;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_sel_d    = res_sel_q;
          out_best_d   = IDXO_W'(best_slot_q);
          out_total_d  = total_q;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      total_q     <= '0;
      best_slot_q <= '0;
      best_val_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      total_q     <= total_d;
      best_slot_q <= best_slot_d;
      best_val_q  <= best_val_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    raw_q        <= raw_d;
    frac_q       <= frac_d;
    acc_q        <= acc_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    mid_q        <= mid_d;
    res_status_q <= res_status_d;
    res_sel_q    <= res_sel_d;
    out_status_q <= out_status_d;
    out_sel_q    <= out_sel_d;
    out_best_q   <= out_best_d;
    out_total_q  <= out_total_d;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign selected_index_o = out_sel_q;
  assign best_index_o     = out_best_q;
  assign total_fitness_o  = out_total_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_MAX)
    else $error("entry count beyond table size");

  a_write_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> count_q < CNT_MAX)
    else $error("table written while full");

  a_search_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SRCH_CMP |-> lo_q < hi_q)
    else $error("search compare with closed interval");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_DONE)
    else $error("result raised outside completion");

  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q != ST_IDLE)
    else $error("item accepted but sequencer idle");

endmodule

>>> src/rws_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rws_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/rws_mul.sv
// Shared 24 x 20 unsigned multiplier with registered product.
// Depends on rws_pkg for operand widths.
module rws_mul
  import rws_pkg::*;
(
  input  logic               clk_i,
  input  logic [MUL_A_W-1:0] a_i,
  input  logic [MUL_B_W-1:0] b_i,
  output logic [MUL_P_W-1:0] p_o
);

  logic [MUL_P_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= MUL_P_W'(a_i) * MUL_P_W'(b_i);
  end

  assign p_o = p_q;

endmodule

>>> dv/tb.sv
// Self-checking testbench for roulette_wheel_selector: loads and draws go in
// through the input channel, and every result is checked against a predictor.
// Depends on rws_pkg and the RTL under src/.
`timescale 1ns / 100ps

module tb;
  import rws_pkg::*;

  localparam int MAX_POP   = 256;
  localparam int CALM_LEFT = 120;

  typedef struct packed {
    logic              func;
    logic              first;
    logic [RAW_W-1:0]  raw;
    logic [FRAC_W-1:0] frac;
  } sel_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDXO_W-1:0]   sel;
    logic [IDXO_W-1:0]   best;
    logic [TOT_W-1:0]    total;
  } sel_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                func_i = FUNC_LOAD;
  logic                first_of_generation_i = 1'b0;
  logic [RAW_W-1:0]    raw_fitness_i = '0;
  logic [FRAC_W-1:0]   draw_fraction_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic [IDXO_W-1:0]   selected_index_o;
  logic [IDXO_W-1:0]   best_index_o;
  logic [TOT_W-1:0]    total_fitness_o;

  roulette_wheel_selector #(
    .MAX_POPULATION(MAX_POP),
    .FITNESS_BITS  (RAW_W),
    .DRAW_BITS     (FRAC_W)
  ) u_top (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .func_i               (func_i),
    .first_of_generation_i(first_of_generation_i),
    .raw_fitness_i        (raw_fitness_i),
    .draw_fraction_i      (draw_fraction_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .status_o             (status_o),
    .selected_index_o     (selected_index_o),
    .best_index_o         (best_index_o),
    .total_fitness_o      (total_fitness_o)
  );

  // predictor state
  logic [TOT_W-1:0]  cum_sum [MAX_POP];
  int unsigned       n_entries = 0;
  logic [TOT_W-1:0]  run_total = '0;
  logic [IDXO_W-1:0] best_slot = '0;
  logic [SQ_W-1:0]   best_sq = '0;

  sel_item_t   item_backlog [$];
  sel_result_t predicted_picks [$];
  logic        in_took = 1'b0;
  int unsigned n_taken = 0;
  int unsigned n_fail = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  int          hold_left = 0;
  logic        held_long = 1'b0;

  function automatic sel_result_t roulette_predict(sel_item_t it);
    sel_result_t     r;
    logic [SQ_W-1:0] sq;
    logic [TOT_W:0]  sum;
    logic [63:0]     prod;
    logic [TOT_W-1:0] target;
    int unsigned     lo, hi, mid;
    r = '0;
    r.status = STAT_OK;
    if (it.func == FUNC_LOAD) begin
      if (it.first) begin
        n_entries = 0;
        run_total = '0;
        best_sq   = '0;
      end
      if (n_entries >= MAX_POP) begin
        r.status = STAT_FULL;
      end else begin
        sq = it.raw * it.raw;
        if (sq > best_sq) begin
          best_sq   = sq;
          best_slot = IDXO_W'(n_entries);
        end
        sum = run_total + sq;
        run_total = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[TOT_W-1:0];
        cum_sum[n_entries] = run_total;
        r.sel = IDXO_W'(n_entries);
        n_entries++;
      end
    end else if (n_entries < 2) begin
      r.status = STAT_TOO_FEW;
    end else begin
      prod   = 64'(it.frac) * 64'(run_total);
      target = prod[63:FRAC_W];
      lo = 0;
      hi = n_entries - 1;
      while (lo < hi) begin
        mid = (lo + hi) / 2;
        if (cum_sum[mid] > target) hi = mid;
        else lo = mid + 1;
      end
      r.sel = IDXO_W'(hi);
    end
    r.best  = best_slot;
    r.total = run_total;
    return r;
  endfunction

  task automatic queue_item(input logic f, input logic g, input logic [RAW_W-1:0] raw,
                            input logic [FRAC_W-1:0] frac);
    sel_item_t it;
    it = '{f, g, raw, frac};
    item_backlog.push_back(it);
  endtask

  function automatic logic [RAW_W-1:0] pick_fitness();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return RAW_W'($urandom_range(1, 15));
      default: return RAW_W'($urandom);
    endcase
  endfunction

  function automatic logic [FRAC_W-1:0] pick_fraction();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return FRAC_W'($urandom);
    endcase
  endfunction

  // restart, load the rest, then draws with the odd extra load mixed in
  task automatic queue_generation(input int unsigned n_load, input int unsigned n_draw);
    for (int i = 0; i < n_load; i++)
      queue_item(FUNC_LOAD, i == 0, pick_fitness(), FRAC_W'($urandom));
    for (int i = 0; i < n_draw; i++) begin
      if ($urandom_range(0, 9) == 0)
        queue_item(FUNC_LOAD, 1'b0, pick_fitness(), FRAC_W'($urandom));
      queue_item(FUNC_DRAW, 1'($urandom), RAW_W'($urandom), pick_fraction());
    end
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #4ms;
    $display("FAILURE");
    $finish;
  end

  always @(negedge clk_i) begin : drive
    logic      nxt_valid;
    sel_item_t it;
    if (rst_ni) begin
      nxt_valid = in_valid_i && !in_took;
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (item_backlog.size() > 0) begin
          if (item_backlog.size() > CALM_LEFT && $urandom_range(0, 5) == 0) begin
            gap_left = $urandom_range(0, 10);
          end else begin
            it = item_backlog.pop_front();
            nxt_valid = 1'b1;
            func_i                <= it.func;
            first_of_generation_i <= it.first;
            raw_fitness_i         <= it.raw;
            draw_fraction_i       <= it.frac;
          end
        end
      end
      in_valid_i <= nxt_valid;
    end
  end

  always @(negedge clk_i) begin : receive
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (!held_long && n_taken >= 120) begin
        // long hold-off so the block backs up and stalls its input
        held_long = 1'b1;
        hold_left = 299;
        out_stall_i <= 1'b1;
      end else if (item_backlog.size() < CALM_LEFT) begin
        out_stall_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 10);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : watch
    sel_result_t got, want;
    sel_item_t   it;
    if (!rst_ni) begin
      in_took <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got = '{status_o, selected_index_o, best_index_o, total_fitness_o};
        if (predicted_picks.size() == 0) begin
          $display("%0t: result with nothing pending, got %h", $time, got);
          n_fail++;
        end else begin
          want = predicted_picks.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
            n_fail++;
          end
          if (got.sel !== want.sel) begin
            $display("%0t: selected_index exp %0d got %0d", $time, want.sel, got.sel);
            n_fail++;
          end
          if (got.best !== want.best) begin
            $display("%0t: best_index exp %0d got %0d", $time, want.best, got.best);
            n_fail++;
          end
          if (got.total !== want.total) begin
            $display("%0t: total_fitness exp %h got %h", $time, want.total, got.total);
            n_fail++;
          end
        end
      end
      in_took <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        it = '{func_i, first_of_generation_i, raw_fitness_i, draw_fraction_i};
        predicted_picks.push_back(roulette_predict(it));
        n_taken++;
      end
    end
  end

  initial begin : run
    int   r;
    logic big_done;
    big_done = 1'b0;

    // draws before any load, zero squares, ties, best kept over a restart
    queue_item(FUNC_DRAW, 1'b0, '0, '1);
    queue_item(FUNC_LOAD, 1'b0, '0, '0);
    queue_item(FUNC_DRAW, 1'b1, '1, '0);
    queue_item(FUNC_LOAD, 1'b0, '0, '1);
    queue_item(FUNC_DRAW, 1'b0, '0, '0);
    queue_item(FUNC_LOAD, 1'b1, 16'd5, '0);
    queue_item(FUNC_LOAD, 1'b0, 16'd5, '0);
    queue_item(FUNC_LOAD, 1'b0, '1, '0);
    queue_item(FUNC_LOAD, 1'b0, 16'd3, '1);
    queue_item(FUNC_DRAW, 1'b0, '0, '0);
    queue_item(FUNC_DRAW, 1'b0, '0, '1);
    queue_item(FUNC_DRAW, 1'b1, '1, 24'h800000);
    queue_item(FUNC_DRAW, 1'b0, '0, 24'h000001);
    queue_item(FUNC_LOAD, 1'b1, '0, '0);
    queue_item(FUNC_LOAD, 1'b0, '0, '0);
    queue_item(FUNC_DRAW, 1'b0, '0, '1);
    queue_item(FUNC_LOAD, 1'b1, '1, '0);
    queue_item(FUNC_LOAD, 1'b0, 16'd1, '0);
    queue_item(FUNC_DRAW, 1'b0, '0, '1);
    queue_item(FUNC_DRAW, 1'b0, '0, 24'h000001);

    while (item_backlog.size() < 900) begin
      r = $urandom_range(0, 9);
      if (!big_done && item_backlog.size() > 300) begin
        // full table, with the last slot the strict best
        big_done = 1'b1;
        for (int i = 0; i < MAX_POP; i++)
          queue_item(FUNC_LOAD, i == 0,
                     (i == MAX_POP - 1) ? 16'hFFFF : RAW_W'($urandom_range(0, 16'hFFFE)),
                     FRAC_W'($urandom));
        queue_item(FUNC_LOAD, 1'b0, pick_fitness(), FRAC_W'($urandom));
        queue_item(FUNC_LOAD, 1'b0, pick_fitness(), FRAC_W'($urandom));
        for (int i = 0; i < 8; i++)
          queue_item(FUNC_DRAW, 1'($urandom), RAW_W'($urandom), pick_fraction());
      end else if (r == 0) begin
        repeat ($urandom_range(1, 4))
          queue_item(1'($urandom), 1'($urandom), RAW_W'($urandom), FRAC_W'($urandom));
      end else if (r == 1) begin
        queue_generation(1, $urandom_range(1, 2));
      end else if ($urandom_range(0, 7) == 0) begin
        queue_generation($urandom_range(2, 64), $urandom_range(1, 8));
      end else begin
        queue_generation($urandom_range(2, 12), $urandom_range(1, 8));
      end
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (item_backlog.size() != 0 || in_valid_i) @(posedge clk_i);
    while (predicted_picks.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
